### hdl/spi_port_register_model_assert.svh
// Assertion macros for the SPI port register model RTL.
`ifndef SPI_PORT_REGISTER_MODEL_ASSERT_SVH
`define SPI_PORT_REGISTER_MODEL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spi port check failed");

// Consequent must hold in the cycle after the antecedent.
`define SPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spi port check failed");

`endif

### hdl/spm_pkg.sv
// Types, codes and bit positions for the SPI port register model.
package spm_pkg;

	// Operation codes of an input beat
	typedef enum logic [2:0] {
		OP_READ  = 3'd0,
		OP_WRITE = 3'd1,
		OP_TICK  = 3'd2,
		OP_PULL  = 3'd3,
		OP_PUSH  = 3'd4,
		OP_CHECK = 3'd5
	} spm_op_t;

	// Register indexes
	localparam logic [3:0] REG_CTL0  = 4'd0;
	localparam logic [3:0] REG_CTL1  = 4'd1;
	localparam logic [3:0] REG_BR0   = 4'd2;
	localparam logic [3:0] REG_BR1   = 4'd3;
	localparam logic [3:0] REG_STAT  = 4'd4;
	localparam logic [3:0] REG_RXBUF = 4'd5;
	localparam logic [3:0] REG_TXBUF = 4'd6;
	localparam logic [3:0] REG_IE    = 4'd7;
	localparam logic [3:0] REG_IFG   = 4'd8;

	// Bit positions
	localparam int CTL0_7BIT_BIT  = 4;
	localparam int CTL0_MST_BIT   = 3;
	localparam int CTL1_SWRST_BIT = 0;
	localparam int STAT_FE_BIT    = 6;
	localparam int STAT_OE_BIT    = 5;
	localparam int IRQ_RX_BIT     = 0;
	localparam int IRQ_TX_BIT     = 1;

	// Clock source select codes (2 and 3 both pick SMCLK)
	localparam logic [1:0] SEL_UCLK = 2'd0;
	localparam logic [1:0] SEL_ACLK = 2'd1;

	// Shifter delay for 7-bit and 8-bit characters
	localparam logic [15:0] CHAR_DELAY_SHORT = 16'd7;
	localparam logic [15:0] CHAR_DELAY_LONG  = 16'd8;

	localparam logic [7:0] CTL1_RESET = 8'h01;

	typedef struct packed {
		logic [2:0] operation;
		logic [3:0] reg_index;
		logic [7:0] write_data;
		logic [7:0] aclk_step;
		logic [7:0] smclk_step;
	} spm_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       shifted_out_valid;
		logic [7:0] shifted_out_byte;
		logic       tx_irq_raised;
		logic       rx_irq_raised;
		logic       rx_shifter_empty;
		logic       irq_pending;
	} spm_result_t;

	typedef struct packed {
		logic [7:0]  ctl0;
		logic [7:0]  ctl1;
		logic [7:0]  br0;
		logic [7:0]  br1;
		logic [7:0]  stat;
		logic [7:0]  rx_holding;
		logic        rx_holding_full;
		logic [7:0]  rx_shift_byte;
		logic        rx_shift_idle;
		logic        rx_shift_done;
		logic [15:0] rx_countdown;
		logic        slave_got_byte;
		logic [7:0]  tx_holding;
		logic        tx_holding_full;
		logic [7:0]  tx_shift_byte;
		logic        tx_shift_idle;
		logic        tx_shift_done;
		logic [15:0] tx_countdown;
		logic [1:0]  int_enable;
		logic [1:0]  int_flags;
	} spm_state_t;

endpackage

### hdl/spm_item_if.sv
// Input channel: one operation beat with valid/ready handshake.
interface spm_item_if;
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic [3:0] reg_index;
	logic [7:0] write_data;
	logic [7:0] aclk_step;
	logic [7:0] smclk_step;

	modport source (output valid, output operation, output reg_index, output write_data,
		output aclk_step, output smclk_step, input ready);
	modport sink (input valid, input operation, input reg_index, input write_data,
		input aclk_step, input smclk_step, output ready);
endinterface

### hdl/spm_result_if.sv
// Output channel: one result beat with valid/ready handshake.
interface spm_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       shifted_out_valid;
	logic [7:0] shifted_out_byte;
	logic       tx_irq_raised;
	logic       rx_irq_raised;
	logic       rx_shifter_empty;
	logic       irq_pending;

	modport source (output valid, output read_data, output shifted_out_valid,
		output shifted_out_byte, output tx_irq_raised, output rx_irq_raised,
		output rx_shifter_empty, output irq_pending, input ready);
	modport sink (input valid, input read_data, input shifted_out_valid,
		input shifted_out_byte, input tx_irq_raised, input rx_irq_raised,
		input rx_shifter_empty, input irq_pending, output ready);
endinterface

### hdl/spm_in_stage.sv
// Input register: captures one operation beat for the core.
module spm_in_stage
	import spm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	spm_item_if.sink   item,
	input  logic       advance,
	output logic       valid_s1,
	output spm_item_t  item_s1
);

	logic load;

	// Take a beat when the stage is empty or its beat moves on this cycle
	assign item.ready = !valid_s1 || advance;
	assign load       = item.valid && item.ready;

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	// Capture the payload
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.operation  <= item.operation;
			item_s1.reg_index  <= item.reg_index;
			item_s1.write_data <= item.write_data;
			item_s1.aclk_step  <= item.aclk_step;
			item_s1.smclk_step <= item.smclk_step;
		end
	end

endmodule

### hdl/spm_core.sv
// Port state and the single-pass update for one operation.
module spm_core
	import spm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  spm_item_t   item_s1,
	output spm_result_t result
);

	`include "spi_port_register_model_assert.svh"

	spm_state_t st_q;
	spm_state_t st_n;
	logic [1:0] sel;
	logic [7:0] step;
	logic       master;

	// Count a delay down by the selected clock step, stop at zero; UCLK clears it at once
	function automatic logic [15:0] count_down(input logic [15:0] d, input logic [1:0] s,
		input logic [7:0] stp);
		logic [15:0] stp_w;
		stp_w = {8'd0, stp};
		if (s == SEL_UCLK) begin
			return 16'd0;
		end
		return (d > stp_w) ? (d - stp_w) : 16'd0;
	endfunction

	// Port state after reset: soft reset set, both shifters idle
	function automatic spm_state_t reset_state();
		spm_state_t s;
		s               = '0;
		s.ctl1          = CTL1_RESET;
		s.rx_shift_idle = 1'b1;
		s.tx_shift_idle = 1'b1;
		return s;
	endfunction

	assign master = st_q.ctl0[CTL0_MST_BIT];
	assign sel    = st_q.ctl1[7:6];
	assign step   = (sel == SEL_ACLK) ? item_s1.aclk_step : item_s1.smclk_step;

	// Apply one operation to the state and form its result
	always_comb begin
		st_n   = st_q;
		result = '0;
		unique case (spm_op_t'(item_s1.operation))
			OP_READ: begin
				unique case (item_s1.reg_index)
					REG_CTL0: result.read_data = st_q.ctl0;
					REG_CTL1: result.read_data = st_q.ctl1;
					REG_BR0:  result.read_data = st_q.br0;
					REG_BR1:  result.read_data = st_q.br1;
					REG_STAT: result.read_data = st_q.stat;
					REG_RXBUF: begin
						result.read_data          = st_q.rx_holding;
						st_n.int_flags[IRQ_RX_BIT] = 1'b0;
						st_n.rx_holding_full      = 1'b0;
						st_n.stat[STAT_OE_BIT]    = 1'b0;
					end
					REG_TXBUF: begin
						result.read_data          = st_q.tx_holding;
						st_n.int_flags[IRQ_TX_BIT] = 1'b0;
					end
					REG_IE:  result.read_data = {6'd0, st_q.int_enable};
					REG_IFG: result.read_data = {6'd0, st_q.int_flags};
					default: result.read_data = 8'd0;
				endcase
			end
			OP_WRITE: begin
				unique case (item_s1.reg_index)
					REG_CTL0: st_n.ctl0 = item_s1.write_data;
					REG_CTL1: begin
						// A write with soft reset clear in both old and new value clears the port
						if (!item_s1.write_data[CTL1_SWRST_BIT] &&
							!st_q.ctl1[CTL1_SWRST_BIT]) begin
							st_n.int_enable             = 2'd0;
							st_n.int_flags[IRQ_RX_BIT]  = 1'b0;
							st_n.int_flags[IRQ_TX_BIT]  = 1'b1;
							st_n.stat[STAT_OE_BIT]      = 1'b0;
							st_n.stat[STAT_FE_BIT]      = 1'b0;
							st_n.tx_holding_full        = 1'b0;
							st_n.tx_shift_idle          = 1'b1;
							st_n.rx_holding_full        = 1'b0;
							st_n.rx_shift_idle          = 1'b1;
						end
						st_n.ctl1 = item_s1.write_data;
					end
					REG_BR0:  st_n.br0  = item_s1.write_data;
					REG_BR1:  st_n.br1  = item_s1.write_data;
					REG_STAT: st_n.stat = item_s1.write_data;
					REG_TXBUF: begin
						st_n.tx_holding             = item_s1.write_data;
						st_n.tx_holding_full        = 1'b1;
						st_n.int_flags[IRQ_TX_BIT]  = 1'b0;
					end
					REG_IE:  st_n.int_enable = item_s1.write_data[1:0];
					REG_IFG: st_n.int_flags  = item_s1.write_data[1:0];
					default: st_n.ctl0 = st_q.ctl0;
				endcase
			end
			OP_TICK: begin
				// Move the transmit buffer into an idle shifter
				if (st_q.tx_holding_full && st_q.tx_shift_idle &&
					(master || st_q.slave_got_byte)) begin
					st_n.tx_shift_byte   = st_q.tx_holding;
					st_n.tx_holding_full = 1'b0;
					st_n.tx_shift_idle   = 1'b0;
					st_n.tx_shift_done   = 1'b0;
					if (master) begin
						st_n.tx_countdown = st_q.ctl0[CTL0_7BIT_BIT] ?
							CHAR_DELAY_SHORT : CHAR_DELAY_LONG;
					end else begin
						st_n.tx_countdown   = 16'd0;
						st_n.slave_got_byte = 1'b0;
					end
					st_n.int_flags[IRQ_TX_BIT] = 1'b1;
					result.tx_irq_raised       = st_q.int_enable[IRQ_TX_BIT];
				end
				// Advance the transmit shifter
				if (!st_n.tx_shift_idle) begin
					st_n.tx_countdown = count_down(st_n.tx_countdown, sel, step);
					if (st_n.tx_countdown == 16'd0) begin
						st_n.tx_shift_done = 1'b1;
					end
				end
				// Advance the receive shifter
				if (!st_n.rx_shift_idle) begin
					st_n.rx_countdown = count_down(st_n.rx_countdown, sel, step);
					if (st_n.rx_countdown == 16'd0) begin
						st_n.rx_shift_done = 1'b1;
					end
				end
				// Hand a finished byte to the receive buffer
				if (st_n.rx_shift_done) begin
					if (st_n.rx_holding_full) begin
						st_n.stat[STAT_OE_BIT] = 1'b1;
					end
					st_n.rx_holding             = st_n.rx_shift_byte;
					st_n.rx_holding_full        = 1'b1;
					st_n.rx_shift_done          = 1'b0;
					st_n.rx_shift_idle          = 1'b1;
					st_n.int_flags[IRQ_RX_BIT]  = 1'b1;
					result.rx_irq_raised        = st_q.int_enable[IRQ_RX_BIT];
				end
			end
			OP_PULL: begin
				if (st_q.tx_shift_done) begin
					result.shifted_out_valid = 1'b1;
					result.shifted_out_byte  = st_q.tx_shift_byte;
					st_n.tx_shift_done       = 1'b0;
					st_n.tx_shift_idle       = 1'b1;
				end
			end
			OP_PUSH: begin
				st_n.rx_shift_byte = item_s1.write_data;
				st_n.rx_shift_idle = 1'b0;
				st_n.rx_shift_done = 1'b0;
				st_n.rx_countdown  = 16'd0;
				if (!master) begin
					st_n.slave_got_byte = 1'b1;
				end
			end
			OP_CHECK: begin
				result.tx_irq_raised = st_q.int_flags[IRQ_TX_BIT] & st_q.int_enable[IRQ_TX_BIT];
				result.rx_irq_raised = st_q.int_flags[IRQ_RX_BIT] & st_q.int_enable[IRQ_RX_BIT];
				result.irq_pending   = result.tx_irq_raised | result.rx_irq_raised;
			end
			default: result.irq_pending = 1'b0;
		endcase
		result.rx_shifter_empty = st_n.rx_shift_idle;
	end

	// Commit the new state when the beat moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= reset_state();
		end else if (advance) begin
			st_q <= st_n;
		end
	end

	// A successful pull frees the transmit shifter
	`SPM_ASSERT_NEXT(a_pull_frees_tx, clk, arst_n,
		advance && item_s1.operation == OP_PULL && st_q.tx_shift_done,
		st_q.tx_shift_idle && !st_q.tx_shift_done)

	// With UCLK selected a tick finishes a busy receive shifter
	`SPM_ASSERT_NEXT(a_uclk_rx_done, clk, arst_n,
		advance && item_s1.operation == OP_TICK && !st_q.rx_shift_idle && sel == SEL_UCLK,
		st_q.rx_holding_full && st_q.rx_shift_idle && st_q.int_flags[IRQ_RX_BIT])

	// A CTL1 write with soft reset clear in both old and new value sets the transmit flag and clears the enables
	`SPM_ASSERT_NEXT(a_swrst_release, clk, arst_n,
		advance && item_s1.operation == OP_WRITE && item_s1.reg_index == REG_CTL1 &&
		!item_s1.write_data[CTL1_SWRST_BIT] && !st_q.ctl1[CTL1_SWRST_BIT],
		st_q.int_flags[IRQ_TX_BIT] && st_q.int_enable == 2'd0 && !st_q.tx_holding_full)

endmodule

### hdl/spm_out_stage.sv
// Result register: holds one result beat until the sink takes it.
module spm_out_stage
	import spm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	spm_result_if.source result_ch,
	input  logic         load,
	input  spm_result_t  result_d,
	output logic         free
);

	logic        valid_q;
	spm_result_t result_q;

	// Room when empty or when the held beat leaves this cycle
	assign free = !valid_q || result_ch.ready;

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// Capture the result
	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_d;
		end
	end

	assign result_ch.valid             = valid_q;
	assign result_ch.read_data         = result_q.read_data;
	assign result_ch.shifted_out_valid = result_q.shifted_out_valid;
	assign result_ch.shifted_out_byte  = result_q.shifted_out_byte;
	assign result_ch.tx_irq_raised     = result_q.tx_irq_raised;
	assign result_ch.rx_irq_raised     = result_q.rx_irq_raised;
	assign result_ch.rx_shifter_empty  = result_q.rx_shifter_empty;
	assign result_ch.irq_pending       = result_q.irq_pending;

endmodule

### hdl/spi_port_register_model.sv
// Top level of the SPI port register model.
// Each beat on item is one operation (register read or write, clock tick, partner pull,
// partner push, interrupt check) and gives exactly one beat on result. The port takes one
// beat per cycle unless the result sink stalls: a beat is held in the input register, the
// port state and the result are updated in a single pass as it moves on, and the result
// is registered in the result register. A result waiting on a stalled sink still lets one
// more beat enter the input register; ready drops only when both registers are full.
// Reset puts the port in soft reset with both shifters idle.
module spi_port_register_model
	import spm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	spm_item_if.sink     item,
	spm_result_if.source result
);

	logic        valid_s1;
	spm_item_t   item_s1;
	logic        out_free;
	logic        advance;
	spm_result_t core_result;

	// Move a beat from the input register when the result register has room
	assign advance = valid_s1 && out_free;

	spm_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	spm_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.result  (core_result)
	);

	spm_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.result_ch (result),
		.load      (advance),
		.result_d  (core_result),
		.free      (out_free)
	);

endmodule

### verif/tb_spi_port_register_model.sv
// Self-checking testbench for the SPI port register model: directed table, then random beats.
module tb_spi_port_register_model
	import spm_pkg::*;
;

	// Codes the package leaves unnamed
	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam logic [3:0] REG_NONE  = 4'd15;

	localparam int HOLD_CYCLES  = 60;
	localparam int DRAIN_LIMIT  = 1000;

	typedef struct {
		spm_item_t   beat;
		bit          typed;
		spm_result_t want;
	} drill_row_t;

	logic clk = 1'b0;
	logic arst_n;

	spm_item_if   item_bus ();
	spm_result_if result_bus ();

	spi_port_register_model i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus)
	);

	// Predicted port state and results still owed by the block
	spm_state_t  port_st;
	spm_result_t due_results[$];
	spm_item_t   plan[$];
	drill_row_t  drill_rows[$];
	int          errors = 0;
	bit          src_gaps = 1'b1;
	bit          sink_gaps = 1'b1;
	bit          hold_req = 1'b0;

	always #1 clk = ~clk;

	// Report one mismatch and count it
	task automatic flag_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got 0x%0h, want 0x%0h", what, got, want);
		errors++;
	endtask

	// Count a shifter delay down by the selected clock step, saturating at zero; UCLK clears it at once
	function automatic logic [15:0] clock_down(logic [15:0] d, logic [1:0] sel,
		logic [7:0] a, logic [7:0] s);
		logic [15:0] stp;
		if (sel == SEL_UCLK) return '0;
		stp = (sel == SEL_ACLK) ? {8'h00, a} : {8'h00, s};
		return (d > stp) ? d - stp : '0;
	endfunction

	// Apply one beat to the predicted state and return the result it gives
	function automatic spm_result_t spi_port_step(spm_item_t it);
		spm_result_t r;
		logic        mst;
		logic [1:0]  sel;
		r = '0;
		mst = port_st.ctl0[CTL0_MST_BIT];
		sel = port_st.ctl1[7:6];
		case (it.operation)
			OP_READ: begin
				case (it.reg_index)
					REG_CTL0: r.read_data = port_st.ctl0;
					REG_CTL1: r.read_data = port_st.ctl1;
					REG_BR0: r.read_data = port_st.br0;
					REG_BR1: r.read_data = port_st.br1;
					REG_STAT: r.read_data = port_st.stat;
					REG_RXBUF: begin
						r.read_data = port_st.rx_holding;
						port_st.int_flags[IRQ_RX_BIT] = 1'b0;
						port_st.rx_holding_full = 1'b0;
						port_st.stat[STAT_OE_BIT] = 1'b0;
					end
					REG_TXBUF: begin
						r.read_data = port_st.tx_holding;
						port_st.int_flags[IRQ_TX_BIT] = 1'b0;
					end
					REG_IE: r.read_data = {6'b0, port_st.int_enable};
					REG_IFG: r.read_data = {6'b0, port_st.int_flags};
					default: r.read_data = '0;
				endcase
			end
			OP_WRITE: begin
				case (it.reg_index)
					REG_CTL0: port_st.ctl0 = it.write_data;
					REG_CTL1: begin
						// both soft reset bits low: drop buffers, shifters and enables
						if (!it.write_data[CTL1_SWRST_BIT] && !port_st.ctl1[CTL1_SWRST_BIT]) begin
							port_st.int_enable = '0;
							port_st.int_flags[IRQ_RX_BIT] = 1'b0;
							port_st.int_flags[IRQ_TX_BIT] = 1'b1;
							port_st.stat[STAT_OE_BIT] = 1'b0;
							port_st.stat[STAT_FE_BIT] = 1'b0;
							port_st.tx_holding_full = 1'b0;
							port_st.tx_shift_idle = 1'b1;
							port_st.rx_holding_full = 1'b0;
							port_st.rx_shift_idle = 1'b1;
						end
						port_st.ctl1 = it.write_data;
					end
					REG_BR0: port_st.br0 = it.write_data;
					REG_BR1: port_st.br1 = it.write_data;
					REG_STAT: port_st.stat = it.write_data;
					REG_TXBUF: begin
						port_st.tx_holding = it.write_data;
						port_st.tx_holding_full = 1'b1;
						port_st.int_flags[IRQ_TX_BIT] = 1'b0;
					end
					REG_IE: port_st.int_enable = it.write_data[1:0];
					REG_IFG: port_st.int_flags = it.write_data[1:0];
					default: ;
				endcase
			end
			OP_TICK: begin
				// load the transmit shifter
				if (port_st.tx_holding_full && port_st.tx_shift_idle &&
					(mst || port_st.slave_got_byte)) begin
					port_st.tx_shift_byte = port_st.tx_holding;
					port_st.tx_holding_full = 1'b0;
					port_st.tx_shift_idle = 1'b0;
					port_st.tx_shift_done = 1'b0;
					if (mst) begin
						port_st.tx_countdown = port_st.ctl0[CTL0_7BIT_BIT] ?
							CHAR_DELAY_SHORT : CHAR_DELAY_LONG;
					end else begin
						port_st.tx_countdown = '0;
						port_st.slave_got_byte = 1'b0;
					end
					port_st.int_flags[IRQ_TX_BIT] = 1'b1;
					if (port_st.int_enable[IRQ_TX_BIT]) r.tx_irq_raised = 1'b1;
				end
				// advance both shifter delays
				if (!port_st.tx_shift_idle) begin
					port_st.tx_countdown = clock_down(port_st.tx_countdown, sel,
						it.aclk_step, it.smclk_step);
					if (port_st.tx_countdown == '0) port_st.tx_shift_done = 1'b1;
				end
				if (!port_st.rx_shift_idle) begin
					port_st.rx_countdown = clock_down(port_st.rx_countdown, sel,
						it.aclk_step, it.smclk_step);
					if (port_st.rx_countdown == '0) port_st.rx_shift_done = 1'b1;
				end
				// move a finished receive into the buffer, flag overrun
				if (port_st.rx_shift_done) begin
					if (port_st.rx_holding_full) port_st.stat[STAT_OE_BIT] = 1'b1;
					port_st.rx_holding = port_st.rx_shift_byte;
					port_st.rx_holding_full = 1'b1;
					port_st.rx_shift_done = 1'b0;
					port_st.rx_shift_idle = 1'b1;
					port_st.int_flags[IRQ_RX_BIT] = 1'b1;
					if (port_st.int_enable[IRQ_RX_BIT]) r.rx_irq_raised = 1'b1;
				end
			end
			OP_PULL: begin
				if (port_st.tx_shift_done) begin
					r.shifted_out_valid = 1'b1;
					r.shifted_out_byte = port_st.tx_shift_byte;
					port_st.tx_shift_done = 1'b0;
					port_st.tx_shift_idle = 1'b1;
				end
			end
			OP_PUSH: begin
				port_st.rx_shift_byte = it.write_data;
				port_st.rx_shift_idle = 1'b0;
				port_st.rx_shift_done = 1'b0;
				port_st.rx_countdown = '0;
				if (!mst) port_st.slave_got_byte = 1'b1;
			end
			OP_CHECK: begin
				r.tx_irq_raised = port_st.int_flags[IRQ_TX_BIT] & port_st.int_enable[IRQ_TX_BIT];
				r.rx_irq_raised = port_st.int_flags[IRQ_RX_BIT] & port_st.int_enable[IRQ_RX_BIT];
				r.irq_pending = r.tx_irq_raised | r.rx_irq_raised;
			end
			default: ;
		endcase
		r.rx_shifter_empty = port_st.rx_shift_idle;
		return r;
	endfunction

	function automatic spm_result_t mk_result(logic [7:0] rd, logic sv, logic [7:0] sb,
		logic txi, logic rxi, logic rse, logic pend);
		spm_result_t r;
		r.read_data = rd;
		r.shifted_out_valid = sv;
		r.shifted_out_byte = sb;
		r.tx_irq_raised = txi;
		r.rx_irq_raised = rxi;
		r.rx_shifter_empty = rse;
		r.irq_pending = pend;
		return r;
	endfunction

	function automatic spm_item_t mk_item(logic [2:0] op, logic [3:0] idx, logic [7:0] data,
		logic [7:0] a, logic [7:0] s);
		spm_item_t it;
		it.operation = op;
		it.reg_index = idx;
		it.write_data = data;
		it.aclk_step = a;
		it.smclk_step = s;
		return it;
	endfunction

	task automatic add_row(spm_item_t it, bit typed = 1'b0, spm_result_t want = '0);
		drill_row_t row;
		row.beat = it;
		row.typed = typed;
		row.want = want;
		drill_rows.push_back(row);
	endtask

	// Small steps most of the time so that delays span several ticks
	function automatic logic [7:0] pick_step();
		return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 4)) : 8'($urandom_range(0, 255));
	endfunction

	task automatic plan_beat(logic [2:0] op, logic [3:0] idx, logic [7:0] data);
		plan.push_back(mk_item(op, idx, data, pick_step(), pick_step()));
	endtask

	// Queue one random beat, or one transfer: optional reconfigure, load, push, ticks, pull, read back
	task automatic plan_transfer();
		int n_ticks;
		if ($urandom_range(0, 99) < 15) begin
			plan_beat(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), 8'($urandom));
			return;
		end
		if ($urandom_range(0, 99) < 20) begin
			plan_beat(OP_WRITE, REG_CTL0, 8'($urandom));
			plan_beat(OP_WRITE, REG_CTL1,
				{2'($urandom), 5'($urandom), 1'($urandom_range(0, 3) == 0)});
			plan_beat(OP_WRITE, REG_IE, 8'($urandom));
		end
		if ($urandom_range(0, 3) != 0) plan_beat(OP_WRITE, REG_TXBUF, 8'($urandom));
		if ($urandom_range(0, 3) != 0) plan_beat(OP_PUSH, 4'($urandom_range(0, 15)), 8'($urandom));
		n_ticks = $urandom_range(1, 4);
		repeat (n_ticks) plan_beat(OP_TICK, 4'($urandom_range(0, 15)), 8'($urandom));
		plan_beat(OP_PULL, 4'($urandom_range(0, 15)), 8'($urandom));
		if ($urandom_range(0, 2) != 0) plan_beat(OP_READ, REG_RXBUF, 8'($urandom));
		if ($urandom_range(0, 1) != 0) plan_beat(OP_CHECK, 4'($urandom_range(0, 15)), 8'($urandom));
		if ($urandom_range(0, 3) == 0) plan_beat(OP_READ, 4'($urandom_range(0, 8)), 8'($urandom));
		if ($urandom_range(0, 7) == 0) plan_beat(OP_WRITE, 4'($urandom_range(0, 8)), 8'($urandom));
	endtask

	// Offer one beat on the item channel and record what it must produce
	task automatic offer_beat(spm_item_t it, bit typed, spm_result_t want);
		spm_result_t pred;
		if (src_gaps && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			item_bus.valid <= 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
		@(negedge clk);
		item_bus.valid <= 1'b1;
		item_bus.operation <= it.operation;
		item_bus.reg_index <= it.reg_index;
		item_bus.write_data <= it.write_data;
		item_bus.aclk_step <= it.aclk_step;
		item_bus.smclk_step <= it.smclk_step;
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
		pred = spi_port_step(it);
		due_results.push_back(typed ? want : pred);
	endtask

	task automatic play_items(int n);
		int sent;
		sent = 0;
		while (sent < n) begin
			if (plan.size() == 0) plan_transfer();
			offer_beat(plan.pop_front(), 1'b0, '0);
			sent++;
		end
	endtask

	// Compare a delivered result beat with the oldest one owed
	task automatic check_result();
		spm_result_t want;
		if (due_results.size() == 0) begin
			flag_mismatch("result beat with none due", result_bus.read_data, 0);
			return;
		end
		want = due_results.pop_front();
		if (result_bus.read_data !== want.read_data)
			flag_mismatch("read_data", result_bus.read_data, want.read_data);
		if (result_bus.shifted_out_valid !== want.shifted_out_valid)
			flag_mismatch("shifted_out_valid", result_bus.shifted_out_valid, want.shifted_out_valid);
		if (result_bus.shifted_out_byte !== want.shifted_out_byte)
			flag_mismatch("shifted_out_byte", result_bus.shifted_out_byte, want.shifted_out_byte);
		if (result_bus.tx_irq_raised !== want.tx_irq_raised)
			flag_mismatch("tx_irq_raised", result_bus.tx_irq_raised, want.tx_irq_raised);
		if (result_bus.rx_irq_raised !== want.rx_irq_raised)
			flag_mismatch("rx_irq_raised", result_bus.rx_irq_raised, want.rx_irq_raised);
		if (result_bus.rx_shifter_empty !== want.rx_shifter_empty)
			flag_mismatch("rx_shifter_empty", result_bus.rx_shifter_empty, want.rx_shifter_empty);
		if (result_bus.irq_pending !== want.irq_pending)
			flag_mismatch("irq_pending", result_bus.irq_pending, want.irq_pending);
	endtask

	// Sample result beats at the rising edge
	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) check_result();
	end

	// Drive result ready: random stall bursts, or one long hold-off on request
	initial begin : sink_drive
		int gap;
		result_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
				result_bus.ready <= 1'b0;
				gap = $urandom_range(1, 7);
				repeat (gap - 1) @(negedge clk);
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	// Stop a hung run
	initial begin : watchdog
		#400000;
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		int drain;
		item_bus.valid = 1'b0;
		item_bus.operation = OP_READ;
		item_bus.reg_index = REG_CTL0;
		item_bus.write_data = '0;
		item_bus.aclk_step = '0;
		item_bus.smclk_step = '0;
		arst_n = 1'b0;

		// predicted state after reset
		port_st = '0;
		port_st.ctl1 = CTL1_RESET;
		port_st.rx_shift_idle = 1'b1;
		port_st.tx_shift_idle = 1'b1;

		// directed table: reset values, bad codes, one pass through each mode
		add_row(mk_item(OP_READ, REG_CTL1, 8'h00, 8'h00, 8'h00), 1'b1,
			mk_result(CTL1_RESET, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0));
		add_row(mk_item(OP_UNUSED, REG_NONE, 8'hff, 8'hff, 8'hff), 1'b1,
			mk_result(8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0));
		add_row(mk_item(OP_READ, REG_NONE, 8'hff, 8'h00, 8'h00), 1'b1,
			mk_result(8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0));
		add_row(mk_item(OP_PULL, REG_CTL0, 8'h00, 8'h00, 8'h00), 1'b1,
			mk_result(8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0));
		add_row(mk_item(OP_WRITE, REG_CTL1, 8'h00, 8'h00, 8'h00));
		add_row(mk_item(OP_WRITE, REG_CTL0, 8'h08, 8'h00, 8'h00));
		add_row(mk_item(OP_WRITE, REG_IE, 8'hff, 8'h00, 8'h00));
		add_row(mk_item(OP_READ, REG_IE, 8'h00, 8'h00, 8'h00), 1'b1,
			mk_result(8'h03, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0));
		add_row(mk_item(OP_WRITE, REG_TXBUF, 8'hff, 8'h00, 8'h00));
		add_row(mk_item(OP_TICK, REG_CTL0, 8'h00, 8'h00, 8'h00));
		add_row(mk_item(OP_PULL, REG_CTL0, 8'h00, 8'h00, 8'h00));
		add_row(mk_item(OP_PUSH, REG_CTL0, 8'ha5, 8'h00, 8'h00));
		add_row(mk_item(OP_TICK, REG_CTL0, 8'h00, 8'h00, 8'h00));
		add_row(mk_item(OP_PUSH, REG_CTL0, 8'h00, 8'h00, 8'h00));
		add_row(mk_item(OP_TICK, REG_NONE, 8'h00, 8'hff, 8'hff));
		add_row(mk_item(OP_READ, REG_STAT, 8'h00, 8'h00, 8'h00));
		add_row(mk_item(OP_READ, REG_RXBUF, 8'h00, 8'h00, 8'h00));
		add_row(mk_item(OP_CHECK, REG_CTL0, 8'h00, 8'h00, 8'h00));
		add_row(mk_item(OP_WRITE, REG_RXBUF, 8'h77, 8'h00, 8'h00));
		add_row(mk_item(OP_WRITE, REG_NONE, 8'hff, 8'h00, 8'h00));
		add_row(mk_item(OP_WRITE, REG_CTL1, 8'hc0, 8'h00, 8'h00));
		add_row(mk_item(OP_WRITE, REG_IFG, 8'hff, 8'h00, 8'h00));
		add_row(mk_item(OP_READ, REG_IFG, 8'h00, 8'h00, 8'h00), 1'b1,
			mk_result(8'h03, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0));
		add_row(mk_item(OP_WRITE, REG_CTL0, 8'h10, 8'h00, 8'h00));
		add_row(mk_item(OP_WRITE, REG_TXBUF, 8'h5a, 8'h00, 8'h00));
		add_row(mk_item(OP_TICK, REG_CTL0, 8'h00, 8'h00, 8'h01));
		add_row(mk_item(OP_PUSH, REG_CTL0, 8'h3c, 8'h00, 8'h00));
		add_row(mk_item(OP_TICK, REG_CTL0, 8'h00, 8'h00, 8'h03));
		add_row(mk_item(OP_PULL, REG_CTL0, 8'h00, 8'h00, 8'h00));
		add_row(mk_item(OP_WRITE, REG_CTL1, 8'h41, 8'h00, 8'h00));
		add_row(mk_item(OP_WRITE, REG_CTL0, 8'h18, 8'h00, 8'h00));
		add_row(mk_item(OP_WRITE, REG_TXBUF, 8'h81, 8'h00, 8'h00));
		add_row(mk_item(OP_TICK, REG_CTL0, 8'h00, 8'h02, 8'h00));
		add_row(mk_item(OP_TICK, REG_CTL0, 8'h00, 8'hff, 8'h00));
		add_row(mk_item(OP_PULL, REG_CTL0, 8'h00, 8'h00, 8'h00));

		// hold reset, then release on a falling edge
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (drill_rows[i])
			offer_beat(drill_rows[i].beat, drill_rows[i].typed, drill_rows[i].want);

		// random traffic with gaps on both sides
		play_items(300);

		// long hold-off on the result side while beats keep coming
		src_gaps = 1'b0;
		hold_req = 1'b1;
		play_items(20);

		// pause the sender until every owed result has arrived
		@(negedge clk);
		item_bus.valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);

		src_gaps = 1'b1;
		play_items(350);

		// full rate to the end
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		play_items(150);

		@(negedge clk);
		item_bus.valid <= 1'b0;
		drain = 0;
		while (due_results.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (4) @(posedge clk);
		if (due_results.size() != 0)
			flag_mismatch("results never delivered", due_results.size(), 0);

		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
